// ===== rtl/rth_pkg.sv =====
// shared constants for the rgb to hsl converter
package rth_pkg;

    localparam int QUO_BITS  = 16;
    localparam int FRAC_ONE  = 65535;
    localparam int HUE_SIXTY = 3840;
    localparam int HUE_FULL  = 23040;

    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

endpackage

// ===== rtl/rgb_to_hsl.sv =====
// rgb to hsl converter top level
// Converts one RGB pixel per clock into hue (1/64 degree), saturation and
// lightness (16-bit fractions, rounded to nearest) plus an achromatic flag.
// A pixel passes the stage-1 register, then the two parallel bit-per-cycle
// dividers for hue and saturation (one input register plus 16 quotient
// stages each) and the output register. Lightness is a division by a
// constant, done by reciprocal multiplication over the last two stages so
// that it lines up with them. A new pixel enters every cycle, and a stalled
// output holds the whole pipeline.
module rgb_to_hsl #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // red, green, blue
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0]     i_s_axis_tdata,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // hue[14:0], saturation[30:15], lightness[46:31]
    output logic [47:0]                             o_m_axis_tdata,
    // achromatic
    output logic                                    o_m_axis_tuser
);
    import rth_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam int NW = CB + 18;
    localparam int DW = CB + 2;
    localparam int TW = CB + 3;
    localparam int QW = QUO_BITS;
    localparam logic [CB:0] CMAX = (CB+1)'((1 << CB) - 1);

    localparam int LN  = CB + 17;
    localparam int LMW = CB + 18;
    localparam int LSH = 2 * CB + 18;
    localparam int PW  = LN + LMW;
    localparam logic [63:0] LIT_D = 64'(2 * ((1 << CB) - 1));
    localparam logic [63:0] LIT_M = ((64'd1 << LSH) + LIT_D - 64'd1) / LIT_D;

    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // stage 1: extremes, sum, delta, hue sector offset
    logic [CB-1:0] in_r, in_g, in_b, hi, lo;
    logic [TW-1:0] n_t;
    logic [1:0]    sect;

    assign in_r = i_s_axis_tdata[CB-1:0];
    assign in_g = i_s_axis_tdata[2*CB-1:CB];
    assign in_b = i_s_axis_tdata[3*CB-1:2*CB];

    always_comb begin
        hi = in_r;
        lo = in_r;
        if (in_g > hi) hi = in_g;
        if (in_b > hi) hi = in_b;
        if (in_g < lo) lo = in_g;
        if (in_b < lo) lo = in_b;
        if (in_r == hi)      sect = SECT_RED;
        else if (in_g == hi) sect = SECT_GREEN;
        else                 sect = SECT_BLUE;
        case (sect)
            SECT_RED:
                n_t = (in_g >= in_b) ? TW'(in_g - in_b)
                    : TW'(6 * TW'(hi - lo)) - TW'(in_b - in_g);
            SECT_GREEN:
                n_t = (in_b >= in_r) ? TW'(2 * TW'(hi - lo)) + TW'(in_b - in_r)
                    : TW'(2 * TW'(hi - lo)) - TW'(in_r - in_b);
            default:
                n_t = (in_r >= in_g) ? TW'(4 * TW'(hi - lo)) + TW'(in_r - in_g)
                    : TW'(4 * TW'(hi - lo)) - TW'(in_g - in_r);
        endcase
    end

    logic          r_v1, r_ach1;
    logic [CB:0]   r_sum;
    logic [CB-1:0] r_delta;
    logic [TW-1:0] r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum   <= (CB+1)'(hi) + (CB+1)'(lo);
            r_delta <= hi - lo;
            r_t     <= n_t;
            r_ach1  <= (hi == lo);
        end
    end

    // numerators and denominators for rounded division
    logic [CB:0]   den;
    logic [NW-1:0] sat_n, hue_n;
    logic [DW-1:0] sat_d, hue_d;

    always_comb begin
        den   = (r_sum <= CMAX) ? r_sum : (CB+1)'(2 * (CB+2)'(CMAX) - (CB+2)'(r_sum));
        sat_n = NW'(2) * NW'(r_delta) * NW'(FRAC_ONE) + NW'(den);
        sat_d = DW'(den) << 1;
        hue_n = NW'(2) * NW'(r_t) * NW'(HUE_SIXTY) + NW'(r_delta);
        hue_d = DW'(r_delta) << 1;
    end

    logic [QW-1:0] sat_q, hue_q;

    rth_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_sat_div (
        .i_clk(i_clk), .i_en(en), .i_num(sat_n), .i_den(sat_d), .o_quo(sat_q)
    );
    rth_div #(.NUM_BITS(NW), .DEN_BITS(DW)) u_hue_div (
        .i_clk(i_clk), .i_en(en), .i_num(hue_n), .i_den(hue_d), .o_quo(hue_q)
    );

    // valid and flag travel beside the dividers
    logic r_vd  [0:QW];
    logic r_achd[0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= QW; i++) r_vd[i] <= 1'b0;
        end else if (en) begin
            r_vd[0] <= r_v1;
            for (int i = 1; i <= QW; i++) r_vd[i] <= r_vd[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_achd[0] <= r_ach1;
            for (int i = 1; i <= QW; i++) r_achd[i] <= r_achd[i-1];
        end
    end

    // lightness: sum delayed, then split multiply by the reciprocal of 2*max
    logic [CB:0]     r_sumd [0:QW-2];
    logic [LN-1:0]   lit_x;
    logic [LN+15:0]  r_lp_lo;
    logic [PW-17:0]  r_lp_hi;
    logic [PW-1:0]   lit_p;
    logic [QW-1:0]   r_lq;

    always_comb begin
        lit_x = LN'(r_sumd[QW-2]) * LN'(FRAC_ONE) + LN'(CMAX);
        lit_p = (PW'(r_lp_hi) << 16) + PW'(r_lp_lo);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sumd[0] <= r_sum;
            for (int i = 1; i <= QW-2; i++) r_sumd[i] <= r_sumd[i-1];
            r_lp_lo <= (LN+16)'(lit_x) * (LN+16)'(LIT_M[15:0]);
            r_lp_hi <= (PW-16)'(lit_x) * (PW-16)'(LIT_M[LMW-1:16]);
            r_lq    <= lit_p[LSH +: QW];
        end
    end

    // output stage: hue wrap and grey override
    logic [14:0] n_hue;
    logic [15:0] n_sat;
    logic        r_ov;
    logic [47:0] r_odata;
    logic        r_ouser;

    always_comb begin
        n_hue = (hue_q >= QW'(HUE_FULL)) ? 15'(hue_q - QW'(HUE_FULL)) : 15'(hue_q);
        n_sat = sat_q;
        if (r_achd[QW]) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vd[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_odata <= {1'b0, r_lq, n_sat, n_hue};
            r_ouser <= r_achd[QW];
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;

    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata[30:0] == 31'd0))
        else $error("grey pixel with nonzero hue or saturation");
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[14:0] < 15'(HUE_FULL)))
        else $error("hue out of range");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

// ===== rtl/rth_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rth_div #(
    parameter int NUM_BITS = 26,
    parameter int DEN_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [NUM_BITS-1:0]         i_num,
    input  logic [DEN_BITS-1:0]         i_den,
    output logic [rth_pkg::QUO_BITS-1:0] o_quo
);
    import rth_pkg::*;

    localparam int QW = QUO_BITS;
    localparam int CW = DEN_BITS + QW;

    logic [CW-1:0]       r_rem [0:QW-1];
    logic [DEN_BITS-1:0] r_den [0:QW-1];
    logic [QW-1:0]       r_quo [0:QW];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= CW'(i_num);
            r_den[0] <= i_den;
            r_quo[0] <= '0;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_quo;
        logic [CW-1:0] shd;

        always_comb begin
            shd   = CW'(r_den[k]) << B;
            n_rem = r_rem[k];
            n_quo = r_quo[k];
            if (r_rem[k] >= shd) begin
                n_rem    = r_rem[k] - shd;
                n_quo[B] = 1'b1;
            end
        end

        if (k < QW - 1) begin : g_mid
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k+1] <= n_rem;
                    r_den[k+1] <= r_den[k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[k+1] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[QW];

endmodule
